### hdl/kwsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_pkg
// Types and constants shared by the k-way sorted merge block.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam int LISTS_DEF = 8;
    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_FULL   = 2'd1,
        ST_POPPED = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_LAST,
        S_POP
    } t_state;

    typedef struct packed {
        logic                     mode;
        logic [IDX_W-1:0]         list_index;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] out_value;
        logic [IDX_W-1:0]         source_list;
    } t_out;

endpackage

### hdl/k_way_sorted_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Per-list fifos in one shared element ram; a pop scans all list heads with
// a single comparator and removes the smallest (lowest list wins ties).
// ----------------------------------------------------------------------------
// a load transaction goes through the LOAD state to its result strobe, a pop
//   through SCAN (one ram read per non-empty list head), LAST and POP
// busy holds off any new transaction until the last one is done; start is
//   taken again in the cycle the result strobe is up
// reset: synchronous active low, clears all list pointers; ram is not cleared
// results are shown for one cycle on o_done, the receiver cannot stall
module k_way_sorted_merge #(
    parameter int LISTS = kwsm_pkg::LISTS_DEF,
    parameter int DEPTH = kwsm_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  kwsm_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_done,
    output kwsm_pkg::t_out o_result
);

    localparam int LW = $clog2(LISTS);
    localparam int PW = $clog2(2 * DEPTH);
    localparam int FW = PW + 1;
    localparam int OW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW = (LISTS * DEPTH > 1) ? $clog2(LISTS * DEPTH) : 1;
    localparam int DW = kwsm_pkg::DATA_W;

    kwsm_pkg::t_state r_state, n_state;

    kwsm_pkg::t_in         r_cmd;
    logic [LW-1:0]         r_cnt;
    logic [PW-1:0]         r_rd_ptr [LISTS];
    logic [PW-1:0]         r_wr_ptr [LISTS];

    logic                  r_q_vld;
    logic [LW-1:0]         r_q_lst;
    logic [PW-1:0]         r_q_ptr;
    logic signed [DW-1:0]  r_rd_data;

    logic                  r_found;
    logic [LW-1:0]         r_best;
    logic [PW-1:0]         r_best_ptr;
    logic signed [DW-1:0]  r_best_val;

    logic                  r_out_vld;
    kwsm_pkg::t_out        r_out;

    logic signed [DW-1:0]  mem [LISTS * DEPTH];

    logic                  accept;
    logic                  scan_last;
    logic [LW-1:0]         sel;
    logic [PW-1:0]         sel_rd, sel_wr, slot_ptr;
    logic                  sel_empty;
    logic [FW-1:0]         sel_fill;
    logic                  ld_ok;
    logic [OW-1:0]         slot_off;
    logic [AW-1:0]         slot_addr;
    logic                  take;
    logic                  mem_we, mem_re, fin_load, fin_pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        if (p == PW'(2 * DEPTH - 1)) begin
            return '0;
        end
        return PW'(p + 1'b1);
    endfunction

    assign accept    = start && !busy;
    assign busy      = (r_state != kwsm_pkg::S_IDLE);
    assign scan_last = (r_cnt == LW'(LISTS - 1));

    // one pointer read port: load list during a load, scan counter otherwise
    assign sel       = (r_state == kwsm_pkg::S_LOAD) ? LW'(r_cmd.list_index) : r_cnt;
    assign sel_rd    = r_rd_ptr[sel];
    assign sel_wr    = r_wr_ptr[sel];
    assign sel_empty = (sel_rd == sel_wr);
    assign sel_fill  = (sel_wr >= sel_rd) ? FW'(sel_wr - sel_rd)
                                          : FW'(FW'(sel_wr) + FW'(2 * DEPTH) - FW'(sel_rd));
    assign ld_ok     = (int'(r_cmd.list_index) < LISTS) && (sel_fill < FW'(DEPTH));

    assign slot_ptr  = (r_state == kwsm_pkg::S_LOAD) ? sel_wr : sel_rd;
    assign slot_off  = (slot_ptr >= PW'(DEPTH)) ? OW'(slot_ptr - PW'(DEPTH)) : OW'(slot_ptr);
    assign slot_addr = AW'(AW'(sel) * AW'(DEPTH) + AW'(slot_off));

    // strict less-than keeps the lower list on ties
    assign take = r_q_vld && (!r_found || (r_rd_data < r_best_val));

    always_comb begin
        n_state = r_state;
        case (r_state)
            kwsm_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_item.mode ? kwsm_pkg::S_SCAN : kwsm_pkg::S_LOAD;
                end
            end
            kwsm_pkg::S_LOAD: n_state = kwsm_pkg::S_IDLE;
            kwsm_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = kwsm_pkg::S_LAST;
                end
            end
            kwsm_pkg::S_LAST: n_state = kwsm_pkg::S_POP;
            kwsm_pkg::S_POP:  n_state = kwsm_pkg::S_IDLE;
            default:          n_state = kwsm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        fin_load = 1'b0;
        fin_pop  = 1'b0;
        case (r_state)
            kwsm_pkg::S_LOAD: begin
                mem_we   = ld_ok;
                fin_load = 1'b1;
            end
            kwsm_pkg::S_SCAN: mem_re  = !sel_empty;
            kwsm_pkg::S_POP:  fin_pop = 1'b1;
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kwsm_pkg::S_IDLE;
            r_out_vld <= 1'b0;
            r_found   <= 1'b0;
            r_q_vld   <= 1'b0;
            r_cnt     <= '0;
            for (int l = 0; l < LISTS; l++) begin
                r_rd_ptr[l] <= '0;
                r_wr_ptr[l] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_out_vld <= fin_load || fin_pop;
            if (accept) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
                r_q_vld <= 1'b0;
            end
            if (r_state == kwsm_pkg::S_SCAN) begin
                r_q_vld <= !sel_empty;
                r_cnt   <= LW'(r_cnt + 1'b1);
            end else if (r_state == kwsm_pkg::S_LAST) begin
                r_q_vld <= 1'b0;
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (fin_load && ld_ok) begin
                r_wr_ptr[sel] <= wrap_inc(sel_wr);
            end
            if (fin_pop && r_found) begin
                r_rd_ptr[r_best] <= wrap_inc(r_best_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_item;
        end
        if (r_state == kwsm_pkg::S_SCAN) begin
            r_q_lst <= r_cnt;
            r_q_ptr <= sel_rd;
        end
        if (take) begin
            r_best     <= r_q_lst;
            r_best_ptr <= r_q_ptr;
            r_best_val <= r_rd_data;
        end
        if (fin_load) begin
            r_out.status      <= ld_ok ? kwsm_pkg::ST_LOADED : kwsm_pkg::ST_FULL;
            r_out.out_value   <= '0;
            r_out.source_list <= '0;
        end else if (fin_pop) begin
            r_out.status      <= r_found ? kwsm_pkg::ST_POPPED : kwsm_pkg::ST_EMPTY;
            r_out.out_value   <= r_found ? r_best_val : '0;
            r_out.source_list <= r_found ? kwsm_pkg::IDX_W'(r_best) : '0;
        end
    end

    // element ram, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[slot_addr] <= r_cmd.value;
        end
        if (mem_re) begin
            r_rd_data <= mem[slot_addr];
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == kwsm_pkg::S_IDLE))
        else $error("result strobe outside idle");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_done)
        else $error("result strobe right after accept");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != kwsm_pkg::ST_POPPED))
        |-> (o_result.out_value == '0) && (o_result.source_list == '0))
        else $error("non-pop result carries data");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kwsm_pkg::S_LOAD) |-> (sel_fill <= FW'(DEPTH)))
        else $error("list fill level above depth");

endmodule

### dv/k_way_sorted_merge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_tb
// Self-checking bench for the k-way sorted merge: directed load/pop cases,
// a list filled past full through pointer wrap, then random merge rounds and
// noise with random sender gaps. Every result is checked against an internal
// per-list fifo predictor.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_tb;

    localparam int     LISTS        = kwsm_pkg::LISTS_DEF;
    localparam int     DEPTH        = kwsm_pkg::DEPTH_DEF;
    localparam int     N_ITEMS      = 1150;
    localparam int     WDOG_LIMIT   = 1000;
    localparam int     DRAIN_CYCLES = LISTS + 8;
    localparam longint VMAX         = 2147483647;
    localparam longint VMIN         = -VMAX - 1;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    kwsm_pkg::t_in  i_item  = '0;
    logic           busy;
    logic           o_done;
    kwsm_pkg::t_out o_result;

    k_way_sorted_merge #(
        .LISTS(LISTS),
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the list fifos
    logic signed [kwsm_pkg::DATA_W-1:0] list_mem [LISTS][DEPTH];
    int unsigned                        list_rd  [LISTS];
    int unsigned                        list_wr  [LISTS];
    kwsm_pkg::t_out                     merge_q  [$];
    int                                 n_err       = 0;
    int                                 n_sent      = 0;
    int                                 idle_cycles = 0;
    bit                                 no_idle     = 1'b0;

    function automatic int unsigned fill_of(int l);
        return (list_wr[l] + 2 * DEPTH - list_rd[l]) % (2 * DEPTH);
    endfunction

    function automatic int unsigned total_fill();
        int unsigned sum;
        sum = 0;
        for (int l = 0; l < LISTS; l++) sum += fill_of(l);
        return sum;
    endfunction

    function automatic kwsm_pkg::t_out merge_step(kwsm_pkg::t_in it);
        kwsm_pkg::t_out                     r;
        int                                 best;
        int                                 idx;
        logic signed [kwsm_pkg::DATA_W-1:0] head;
        logic signed [kwsm_pkg::DATA_W-1:0] best_val;
        r        = '0;
        best     = -1;
        best_val = '0;
        idx      = int'(it.list_index);
        if (it.mode == 1'b0) begin
            if (idx >= LISTS || fill_of(idx) >= DEPTH) begin
                r.status = kwsm_pkg::ST_FULL;
            end else begin
                list_mem[idx][list_wr[idx] % DEPTH] = it.value;
                list_wr[idx] = (list_wr[idx] + 1) % (2 * DEPTH);
                r.status = kwsm_pkg::ST_LOADED;
            end
        end else begin
            // lowest list wins ties: only a strictly smaller head replaces
            for (int l = 0; l < LISTS; l++) begin
                if (fill_of(l) != 0) begin
                    head = list_mem[l][list_rd[l] % DEPTH];
                    if (best < 0 || head < best_val) begin
                        best     = l;
                        best_val = head;
                    end
                end
            end
            if (best >= 0) begin
                list_rd[best] = (list_rd[best] + 1) % (2 * DEPTH);
                r.status      = kwsm_pkg::ST_POPPED;
                r.out_value   = best_val;
                r.source_list = best[kwsm_pkg::IDX_W-1:0];
            end else begin
                r.status = kwsm_pkg::ST_EMPTY;
            end
        end
        return r;
    endfunction

    // result check, prediction on accept, and the stall watchdog
    always @(posedge i_clk) begin : mon
        kwsm_pkg::t_out want;
        if (i_rst_n) begin
            if (o_done) begin
                if (merge_q.size() == 0) begin
                    n_err++;
                    $error("result with no transaction outstanding: status %0d",
                           o_result.status);
                end else begin
                    want = merge_q.pop_front();
                    if (o_result.status !== want.status) begin
                        n_err++;
                        $error("status: expected %0d, got %0d", want.status,
                               o_result.status);
                    end
                    if (o_result.out_value !== want.out_value) begin
                        n_err++;
                        $error("out_value: expected %0d, got %0d", want.out_value,
                               o_result.out_value);
                    end
                    if (o_result.source_list !== want.source_list) begin
                        n_err++;
                        $error("source_list: expected %0d, got %0d", want.source_list,
                               o_result.source_list);
                    end
                end
            end
            if (start && !busy) begin
                merge_q.insert(merge_q.size(), merge_step(i_item));
                n_sent++;
            end
            if (o_done || (start && !busy)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [kwsm_pkg::DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return VMIN[kwsm_pkg::DATA_W-1:0];
            1: return VMAX[kwsm_pkg::DATA_W-1:0];
            2: return '0;
            3: return '1;
            4, 5: return kwsm_pkg::DATA_W'(longint'($urandom_range(0, 16)) - 8);
            default: return $urandom();
        endcase
    endfunction

    function automatic kwsm_pkg::t_in load_item(int l,
                                                logic signed [kwsm_pkg::DATA_W-1:0] v);
        kwsm_pkg::t_in it;
        it.mode       = 1'b0;
        it.list_index = l[kwsm_pkg::IDX_W-1:0];
        it.value      = v;
        return it;
    endfunction

    // list index and value carry noise, a pop must ignore them
    function automatic kwsm_pkg::t_in pop_item();
        kwsm_pkg::t_in it;
        it.mode       = 1'b1;
        it.list_index = kwsm_pkg::IDX_W'($urandom_range(0, 7));
        it.value      = $urandom();
        return it;
    endfunction

    // called right after a rising edge; returns at the accepting edge or after the gap
    task automatic send_item(input kwsm_pkg::t_in it);
        int gap;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= kwsm_pkg::t_in'({$urandom(), $urandom()});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do @(posedge i_clk); while (merge_q.size() != 0);
    endtask

    task automatic pop_n(int n);
        for (int k = 0; k < n; k++) send_item(pop_item());
    endtask

    task automatic load_sorted_run(int l, int n);
        longint v;
        case ($urandom_range(0, 3))
            0: v = longint'($urandom_range(0, 16)) - 8;
            1: v = VMIN + $urandom_range(0, 4);
            default: v = longint'(int'($urandom()));
        endcase
        for (int k = 0; k < n; k++) begin
            send_item(load_item(l, v[kwsm_pkg::DATA_W-1:0]));
            if ($urandom_range(0, 3) == 0) v += longint'($urandom_range(0, 1 << 28));
            else v += $urandom_range(0, 3);
            if (v > VMAX) v = VMAX;
        end
    endtask

    task automatic test_pop_empty();
        send_item(pop_item());
    endtask

    task automatic test_extreme_values();
        send_item(load_item(7, VMAX[kwsm_pkg::DATA_W-1:0]));
        send_item(load_item(0, VMIN[kwsm_pkg::DATA_W-1:0]));
        send_item(load_item(3, '0));
        send_item(load_item(5, '1));
        pop_n(5);
    endtask

    task automatic test_tie_break();
        send_item(load_item(6, 32'sd5));
        send_item(load_item(2, 32'sd5));
        send_item(load_item(4, 32'sd5));
        pop_n(3);
    endtask

    task automatic test_unsorted_load();
        send_item(load_item(1, 32'sd9));
        send_item(load_item(1, 32'sd3));
        send_item(load_item(2, 32'sd5));
        pop_n(4);
    endtask

    // fill one list past full twice so its pointers wrap
    task automatic test_list_full();
        int l;
        l = $urandom_range(0, LISTS - 1);
        for (int pass = 0; pass < 2; pass++) begin
            for (int k = 0; k < DEPTH + 2; k++) send_item(load_item(l, rand_value()));
            pop_n(DEPTH + 1);
        end
        wait_results();
    endtask

    task automatic test_random_traffic();
        int kind;
        int n_loads;
        int n_lists;
        int n_burst;
        int l;
        while (n_sent < N_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            kind    = $urandom_range(0, 9);
            if (kind <= 5) begin
                // sorted runs into several lists, then merge them all out
                n_loads = 0;
                n_lists = $urandom_range(1, LISTS);
                for (int k = 0; k < n_lists; k++) begin
                    l = $urandom_range(0, LISTS - 1);
                    kind = $urandom_range(0, 10);
                    load_sorted_run(l, kind);
                    n_loads += kind;
                end
                pop_n(total_fill() + n_loads + 1);
            end else if (kind <= 8) begin
                for (int k = 0; k < 20; k++) begin
                    if ($urandom_range(0, 1) == 0)
                        send_item(load_item($urandom_range(0, LISTS - 1), rand_value()));
                    else
                        send_item(pop_item());
                end
            end else begin
                // a burst against one list until it reports full
                l       = $urandom_range(0, LISTS - 1);
                n_burst = DEPTH - int'(fill_of(l)) + 2;
                for (int k = 0; k < n_burst; k++)
                    send_item(load_item(l, rand_value()));
                pop_n(total_fill() + 1);
            end
            if ($urandom_range(0, 5) == 0) wait_results();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int l = 0; l < LISTS; l++) begin
            list_rd[l] = 0;
            list_wr[l] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pop_empty();
        test_extreme_values();
        test_tie_break();
        test_unsorted_load();
        wait_results();
        test_list_full();
        test_random_traffic();

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### k_way_sorted_merge.f
hdl/kwsm_pkg.sv
hdl/k_way_sorted_merge.sv
dv/k_way_sorted_merge_tb.sv
